// ===== hdl/irt_pkg.sv =====
// Shared constants, types and helpers of the interval reservation table.
package irt_pkg;
    localparam int POOL_ENTRIES  = 32;
    localparam int NUM_RESOURCES = 22;
    localparam int ENTRY_W = $clog2(POOL_ENTRIES);
    localparam int LINK_W  = $clog2(POOL_ENTRIES + 1);
    localparam int RES_W   = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int STEP_W  = $clog2(POOL_ENTRIES + 1);
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_ENTRIES);
    localparam logic [7:0] NODE_BASE_RST = 8'd80;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_CONFLICT  = 3'd1;
    localparam logic [2:0] ST_POOL_FULL = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_MISMATCH  = 3'd4;
    localparam logic [2:0] ST_BAD_RES   = 3'd5;

    localparam logic MODE_RESERVE = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef struct packed {
        logic              mode;
        logic              bad;
        logic [RES_W-1:0]  res;
        logic [31:0]       start_time;
        logic [31:0]       end_time;
    } t_cmd;

    function automatic logic is_entry(input logic [LINK_W-1:0] l);
        return l < LINK_NULL;
    endfunction

    // Link value a pool entry holds right after reset.
    function automatic logic [LINK_W-1:0] reset_link(input logic [ENTRY_W-1:0] a);
        logic [LINK_W-1:0] nxt;
        nxt = LINK_W'(a) + LINK_W'(1);
        return nxt;
    endfunction
endpackage

// ===== hdl/irt_front.sv =====
// Front end: input channel, resource mapping, classification and command queue.
module irt_front
    import irt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_node_index,
    input  logic [31:0] i_start_time,
    input  logic [31:0] i_end_time,
    output logic        o_q_valid,
    output t_cmd        o_q_cmd,
    input  logic        i_q_pop
);
    logic [7:0] r_node_base;
    t_cmd       r_q [QUEUE_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [7:0] res_full;
    t_cmd       cmd_in;
    logic       push, pop;

    always_comb begin
        res_full          = i_node_index - r_node_base;
        cmd_in.mode       = i_mode;
        cmd_in.bad        = res_full >= 8'(NUM_RESOURCES);
        cmd_in.res        = res_full[RES_W-1:0];
        cmd_in.start_time = i_start_time;
        cmd_in.end_time   = i_end_time;
    end

    assign o_stall   = (r_cnt == 2'(QUEUE_DEPTH));
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_base <= NODE_BASE_RST;
            r_wp        <= 1'b0;
            r_rp        <= 1'b0;
            r_cnt       <= 2'd0;
        end else begin
            if (i_cfg_we) r_node_base <= i_cfg_data;
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= cmd_in;
    end
endmodule

// ===== hdl/irt_back.sv =====
// Back end: list walker, pool memories and result register.
module irt_back
    import irt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_cmd        i_q_cmd,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [4:0]  o_slot
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_WALK  = 7'b0000010,
        S_ALLOC = 7'b0000100,
        S_FILL  = 7'b0001000,
        S_LINK  = 7'b0010000,
        S_REL   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;
    logic [LINK_W-1:0]  r_head [NUM_RESOURCES];
    logic [LINK_W-1:0]  r_free, r_cur, r_prev, r_before, r_after;
    logic               r_placed;
    logic [STEP_W-1:0]  r_steps;
    logic [ENTRY_W-1:0] r_fresh;
    logic [2:0]         r_status;
    logic [ENTRY_W-1:0] r_slot;
    logic               r_ovalid;
    logic [2:0]         r_ostatus;
    logic [4:0]         r_oslot;

    logic [31:0]        m_start [POOL_ENTRIES];
    logic [31:0]        m_end   [POOL_ENTRIES];
    logic [LINK_W-1:0]  m_link  [POOL_ENTRIES];
    logic [POOL_ENTRIES-1:0] r_lvalid;
    logic [31:0]        r_rd_start, r_rd_end;
    logic [LINK_W-1:0]  r_rd_link;

    logic               rd_en;
    logic [ENTRY_W-1:0] rd_addr;
    logic               se_we;
    logic               lk_we;
    logic [ENTRY_W-1:0] lk_addr;
    logic [LINK_W-1:0]  lk_data;
    logic               ov;
    logic [LINK_W-1:0]  head_sel;
    logic [STEP_W-1:0]  steps_nx;

    assign o_valid  = r_ovalid;
    assign o_status = r_ostatus;
    assign o_slot   = r_oslot;
    assign o_q_pop  = (r_state == S_IDLE);

    always_comb begin
        // A bad resource number may lie past the last head, so never index with it.
        head_sel = i_q_cmd.bad ? LINK_NULL : r_head[i_q_cmd.res];
        ov = (r_rd_start <= r_cmd.end_time && r_rd_end >= r_cmd.start_time) ||
             (r_rd_end <= r_cmd.start_time && r_rd_start >= r_cmd.end_time);
        steps_nx = r_steps + STEP_W'(1);
        rd_en   = 1'b0;
        rd_addr = '0;
        se_we   = 1'b0;
        lk_we   = 1'b0;
        lk_addr = '0;
        lk_data = '0;
        case (r_state)
            S_IDLE: begin
                rd_en   = 1'b1;
                rd_addr = head_sel[ENTRY_W-1:0];
            end
            S_WALK: begin
                rd_en   = 1'b1;
                rd_addr = r_rd_link[ENTRY_W-1:0];
            end
            S_ALLOC: begin
                rd_en   = 1'b1;
                rd_addr = r_free[ENTRY_W-1:0];
            end
            S_FILL: begin
                se_we   = 1'b1;
                lk_we   = 1'b1;
                lk_addr = r_fresh;
                lk_data = r_after;
            end
            S_LINK: begin
                lk_we   = is_entry(r_before);
                lk_addr = r_before[ENTRY_W-1:0];
                lk_data = LINK_W'(r_fresh);
            end
            S_REL: begin
                lk_we   = r_rd_start == r_cmd.start_time;
                lk_addr = r_cur[ENTRY_W-1:0];
                lk_data = r_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_start <= m_start[rd_addr];
            r_rd_end   <= m_end[rd_addr];
            r_rd_link  <= r_lvalid[rd_addr] ? m_link[rd_addr] :
                          ((rd_addr == ENTRY_W'(POOL_ENTRIES - 1)) ? LINK_NULL
                                                                   : reset_link(rd_addr));
        end
        if (se_we) begin
            m_start[r_fresh] <= r_cmd.start_time;
            m_end[r_fresh]   <= r_cmd.end_time;
        end
        if (lk_we) m_link[lk_addr] <= lk_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lvalid <= '0;
            r_free   <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < NUM_RESOURCES; i++) r_head[i] <= LINK_NULL;
        end else begin
            if (lk_we) r_lvalid[lk_addr] <= 1'b1;
            if (r_state == S_DONE && (!r_ovalid || !i_stall)) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd    <= i_q_cmd;
                        r_cur    <= head_sel;
                        r_prev   <= LINK_NULL;
                        r_placed <= 1'b0;
                        r_steps  <= '0;
                        r_slot   <= '0;
                        if (i_q_cmd.bad) begin
                            r_status <= ST_BAD_RES;
                            r_state  <= S_DONE;
                        end else if (i_q_cmd.mode == MODE_RELEASE) begin
                            if (is_entry(head_sel)) begin
                                r_state <= S_REL;
                            end else begin
                                r_status <= ST_EMPTY;
                                r_state  <= S_DONE;
                            end
                        end else begin
                            r_state <= is_entry(head_sel) ? S_WALK : S_ALLOC;
                        end
                    end
                end
                S_WALK: begin
                    if (ov) begin
                        r_status <= ST_CONFLICT;
                        r_state  <= S_DONE;
                    end else begin
                        if (!r_placed && r_rd_start > r_cmd.start_time) begin
                            r_placed <= 1'b1;
                            r_before <= r_prev;
                            r_after  <= r_cur;
                        end
                        r_prev  <= r_cur;
                        r_cur   <= r_rd_link;
                        r_steps <= steps_nx;
                        if (!(is_entry(r_rd_link) && steps_nx < STEP_W'(POOL_ENTRIES)))
                            r_state <= S_ALLOC;
                    end
                end
                S_ALLOC: begin
                    if (!is_entry(r_free)) begin
                        r_status <= ST_POOL_FULL;
                        r_state  <= S_DONE;
                    end else begin
                        r_fresh <= r_free[ENTRY_W-1:0];
                        if (!r_placed) begin
                            r_before <= r_prev;
                            r_after  <= r_cur;
                        end
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    r_free  <= r_rd_link;
                    r_state <= S_LINK;
                end
                S_LINK: begin
                    if (!is_entry(r_before)) r_head[r_cmd.res] <= LINK_W'(r_fresh);
                    r_status <= ST_OK;
                    r_slot   <= r_fresh;
                    r_state  <= S_DONE;
                end
                S_REL: begin
                    if (r_rd_start != r_cmd.start_time) begin
                        r_status <= ST_MISMATCH;
                    end else begin
                        r_head[r_cmd.res] <= r_rd_link;
                        r_free   <= r_cur;
                        r_status <= ST_OK;
                        r_slot   <= r_cur[ENTRY_W-1:0];
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || !i_stall) begin
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_ovalid || !i_stall)) begin
            r_ostatus <= r_status;
            r_oslot   <= 5'(r_slot);
        end
    end
endmodule

// ===== hdl/interval_reservation_table.sv =====
// Interval reservation table: per-resource start-ordered interval lists over a shared pool.
// Input channel (i_valid/o_stall) takes reserve or release transactions; output channel
// (o_valid/i_stall) returns one status and slot per transaction, in order.
// i_cfg_we writes node_base (node index of resource zero); the user must write it only
// while the block is idle, which the block itself does not enforce. The front maps the
// node to a resource and queues up to two transactions, so the input keeps flowing while
// the back end works or the receiver stalls. A bad resource goes from idle straight to
// done; a release checks the head entry; a reserve walks the list (a conflict stops the
// walk early), then allocates, fills and links a free entry, if one is left. The back end
// works on one transaction at a time, reading one pool entry per cycle from a single-ported
// pool memory, which sets throughput.
// A stalled result holds in the output register; the back end waits in its done state
// until that register frees.
// Reset (synchronous, active low): all lists empty, all 32 pool entries on the free
// list, node_base 80, queue and output empty. No clearing pass is needed.
// Status codes: ok, conflict, pool full, list empty, start mismatch, bad resource;
// slot is zero on any status but ok.
module interval_reservation_table
    import irt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_node_index,
    input  logic [31:0] i_start_time,
    input  logic [31:0] i_end_time,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [4:0]  o_slot
);
    logic q_valid, q_pop;
    t_cmd q_cmd;

    irt_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data, .i_valid, .o_stall,
        .i_mode, .i_node_index, .i_start_time, .i_end_time,
        .o_q_valid(q_valid), .o_q_cmd(q_cmd), .i_q_pop(q_pop)
    );

    irt_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_cmd(q_cmd), .o_q_pop(q_pop),
        .o_valid, .i_stall, .o_status, .o_slot
    );

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_slot == 5'd0)
        else $error("slot not zero on failure");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_BAD_RES)
        else $error("status code out of range");

    a_bad_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid && q_pop && q_cmd.bad |=> ##1 o_valid && o_status == ST_BAD_RES ||
        $past(o_valid && i_stall))
        else $error("bad resource not reported");
endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench of the interval reservation table with its own prediction.
module testbench
    import irt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic        i_mode;
    logic [7:0]  i_node_index;
    logic [31:0] i_start_time;
    logic [31:0] i_end_time;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_status;
    logic [4:0]  o_slot;

    interval_reservation_table u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_node_index (i_node_index),
        .i_start_time (i_start_time),
        .i_end_time   (i_end_time),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_slot       (o_slot)
    );

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] slot;
    } t_outcome;

    // Predicted table state.
    logic [7:0]  base_node;
    logic [31:0] iv_start [POOL_ENTRIES];
    logic [31:0] iv_end   [POOL_ENTRIES];
    int          iv_next  [POOL_ENTRIES];
    int          res_head [NUM_RESOURCES];
    int          free_top;

    t_outcome    pending_outcomes [$];
    int          errors;
    int          n_sent;
    int          n_checked;
    int          idle_cycles;
    int          send_idle_pct;
    int          stall_pct;
    int          mode_cnt [2];
    int          status_cnt [6];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void table_reset();
        base_node = NODE_BASE_RST;
        for (int i = 0; i < POOL_ENTRIES; i++) begin
            iv_start[i] = '0;
            iv_end[i] = '0;
            iv_next[i] = i + 1;
        end
        for (int r = 0; r < NUM_RESOURCES; r++) res_head[r] = POOL_ENTRIES;
        free_top = 0;
    endfunction

    function automatic bit intervals_clash(logic [31:0] s, logic [31:0] e,
                                           logic [31:0] ns, logic [31:0] ne);
        return (s <= ne && e >= ns) || (e <= ns && s >= ne);
    endfunction

    function automatic t_outcome table_apply(logic mode, logic [7:0] node,
                                             logic [31:0] ns, logic [31:0] ne);
        t_outcome   res;
        logic [7:0] r;
        int         cur;
        int         prev;
        int         after;
        bit         placed;
        int         h;
        int         fresh;
        res = '0;
        r = node - base_node;
        if (r >= NUM_RESOURCES) begin
            res.status = ST_BAD_RES;
            return res;
        end
        if (mode == MODE_RESERVE) begin
            cur = res_head[r];
            prev = POOL_ENTRIES;
            after = POOL_ENTRIES;
            placed = 0;
            while (cur < POOL_ENTRIES) begin
                if (intervals_clash(iv_start[cur], iv_end[cur], ns, ne)) begin
                    res.status = ST_CONFLICT;
                    return res;
                end
                if (!placed && iv_start[cur] > ns) begin
                    placed = 1;
                    after = prev;
                end
                prev = cur;
                cur = iv_next[cur];
            end
            if (!placed) after = prev;
            if (free_top >= POOL_ENTRIES) begin
                res.status = ST_POOL_FULL;
                return res;
            end
            fresh = free_top;
            free_top = iv_next[fresh];
            iv_start[fresh] = ns;
            iv_end[fresh] = ne;
            if (after < POOL_ENTRIES) begin
                iv_next[fresh] = iv_next[after];
                iv_next[after] = fresh;
            end else begin
                iv_next[fresh] = res_head[r];
                res_head[r] = fresh;
            end
            res.status = ST_OK;
            res.slot = fresh[4:0];
        end else begin
            h = res_head[r];
            if (h >= POOL_ENTRIES) begin
                res.status = ST_EMPTY;
                return res;
            end
            if (iv_start[h] != ns) begin
                res.status = ST_MISMATCH;
                return res;
            end
            res_head[r] = iv_next[h];
            iv_next[h] = free_top;
            free_top = h;
            res.status = ST_OK;
            res.slot = h[4:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Check each result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected result, status", o_status, -1);
            end else begin
                t_outcome want;
                want = pending_outcomes.pop_front();
                n_checked++;
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (o_slot !== want.slot) report_mismatch("slot", o_slot, want.slot);
            end
        end
    end

    // Random receiver stall.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog on cycles with no transaction on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending_outcomes.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Leave valid high after the accept; the next send reuses it, a drain drops it.
    task automatic send_item(logic mode, logic [7:0] node, logic [31:0] ns, logic [31:0] ne);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_node_index <= node;
        i_start_time <= ns;
        i_end_time <= ne;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_outcomes.push_back(table_apply(mode, node, ns, ne));
        mode_cnt[mode]++;
        status_cnt[pending_outcomes[$].status]++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_base(logic [7:0] value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        base_node = value;
    endtask

    // Node index of resource r under the current base.
    function automatic logic [7:0] node_of(int r);
        return base_node + 8'(r);
    endfunction

    task automatic test_directed();
        send_item(MODE_RELEASE, node_of(0), 32'd5, 32'd0);
        send_item(MODE_RESERVE, node_of(0), 32'd100, 32'd200);
        send_item(MODE_RESERVE, node_of(0), 32'd200, 32'd300);
        send_item(MODE_RESERVE, node_of(0), 32'd50, 32'd100);
        send_item(MODE_RESERVE, node_of(0), 32'd10, 32'd20);
        send_item(MODE_RESERVE, node_of(0), 32'd300, 32'd400);
        send_item(MODE_RESERVE, node_of(0), 32'd500, 32'd400);
        send_item(MODE_RESERVE, node_of(0), 32'd150, 32'd160);
        send_item(MODE_RESERVE, node_of(0), 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        send_item(MODE_RESERVE, node_of(0), 32'd600, 32'd50);
        send_item(MODE_RESERVE, node_of(0), 32'd0, 32'd0);
        send_item(MODE_RELEASE, node_of(0), 32'd7, 32'd0);
        send_item(MODE_RELEASE, node_of(0), 32'd0, 32'hFFFF_FFFF);
        send_item(MODE_RELEASE, node_of(0), 32'd10, 32'd0);
        send_item(MODE_RESERVE, node_of(NUM_RESOURCES - 1), 32'd1, 32'd2);
        send_item(MODE_RESERVE, node_of(NUM_RESOURCES), 32'd1, 32'd2);
        send_item(MODE_RELEASE, node_of(255), 32'd1, 32'd2);
        send_item(MODE_RELEASE, node_of(NUM_RESOURCES - 1), 32'd1, 32'd0);
        send_item(MODE_RELEASE, node_of(0), 32'd50, 32'd0);
        send_item(MODE_RELEASE, node_of(0), 32'd100, 32'd0);
    endtask

    // Fill the whole pool on a few resources, then hit pool full and conflict-first.
    task automatic test_pool_full();
        for (int i = 0; i < POOL_ENTRIES + 2; i++)
            send_item(MODE_RESERVE, node_of(i % 3 + 1), 32'(i * 1000), 32'(i * 1000 + 10));
        send_item(MODE_RESERVE, node_of(1), 32'd0, 32'd5);
        for (int i = 0; i < POOL_ENTRIES + 2; i++)
            send_item(MODE_RELEASE, node_of(i % 3 + 1), 32'(i * 1000), 32'd0);
        for (int r = 0; r < NUM_RESOURCES; r++)
            while (res_head[r] < POOL_ENTRIES)
                send_item(MODE_RELEASE, node_of(r), iv_start[res_head[r]], 32'd0);
    endtask

    // Mostly well-formed traffic: most releases use the predicted head start.
    task automatic test_random(int count);
        logic [31:0] s;
        logic [31:0] e;
        int          r;
        int          pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            r = (pick < 3) ? $urandom_range(255) : $urandom_range(NUM_RESOURCES - 1);
            if ($urandom_range(99) < 50) begin
                if ($urandom_range(9) == 0) begin
                    s = $urandom;
                    e = $urandom;
                end else begin
                    s = $urandom_range(4000);
                    if ($urandom_range(1)) s = s | 32'hFFFF_0000;
                    e = s + $urandom_range(300);
                end
                send_item(MODE_RESERVE, node_of(r), s, e);
            end else begin
                s = $urandom;
                if (r < NUM_RESOURCES && res_head[r] < POOL_ENTRIES && $urandom_range(9) != 0)
                    s = iv_start[res_head[r]];
                send_item(MODE_RELEASE, node_of(r), s, $urandom);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_mode = 1'b0;
        i_node_index = '0;
        i_start_time = '0;
        i_end_time = '0;
        i_stall = 1'b0;
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        mode_cnt = '{0, 0};
        status_cnt = '{0, 0, 0, 0, 0, 0};
        table_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_pool_full();
        write_base(8'd0);
        test_directed();
        test_random(350);
        send_idle_pct = 71;
        write_base(8'd255);
        test_random(350);
        send_idle_pct = 0;
        stall_pct = 71;
        write_base(8'd240);
        test_pool_full();
        test_random(350);
        send_idle_pct = 17;
        stall_pct = 17;
        write_base(8'($urandom));
        test_random(350);
        drain();

        $display("sent %0d reserves and %0d releases, checked %0d results",
                 mode_cnt[0], mode_cnt[1], n_checked);
        $display("statuses ok/conflict/full/empty/mismatch/bad: %0d %0d %0d %0d %0d %0d",
                 status_cnt[0], status_cnt[1], status_cnt[2],
                 status_cnt[3], status_cnt[4], status_cnt[5]);
        if (errors == 0 && pending_outcomes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/irt_pkg.sv
hdl/irt_front.sv
hdl/irt_back.sv
hdl/interval_reservation_table.sv
sim/testbench.sv
